>>> rtl/bfa_pkg.sv
// Package: widths, constants and request/result types for the best-fit allocator.
package bfa_pkg;
  localparam int MaxSlots   = 64;
  localparam int OffsetBits = 20;
  localparam int SizeBits   = OffsetBits + 1;
  localparam int IdxBits    = $clog2(MaxSlots);
  localparam int CntBits    = $clog2(MaxSlots + 1);
  localparam int AlignMax   = 12;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusFit  = 2'd1;
  localparam logic [1:0] StatusFull = 2'd2;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [20:0] request_size;
    logic [3:0]  align_log2;
    logic [19:0] free_offset;
  } bfa_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] alloc_offset;
    logic [20:0] free_bytes;
  } bfa_res_t;
endpackage

>>> rtl/best_fit_allocator.sv
// Top level: best-fit slot allocator with a sequenced table scan.
// An alignment gap that needs a new slot adds one more write; when the last entry is moved
// into a vacated position, it is first read back and then written there. busy is high until
// the done strobe; one entry is read per cycle through the single read port. Next request is
// taken at the strobe's end. Reset (or a write of cfg_data) sets one whole-arena slot, none
// for a zero arena; the receiver cannot stall.
module best_fit_allocator import bfa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [20:0]  cfg_data,
  input  logic         start,
  input  bfa_req_t     req,
  output logic         busy,
  output logic         done,
  output bfa_res_t     res
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_DECIDE, S_MOVE, S_WRITE} state_t;
  state_t state;

  logic [OffsetBits-1:0] mem_start [MaxSlots];
  logic [SizeBits-1:0]   mem_len   [MaxSlots];
  logic [OffsetBits-1:0] rd_start;
  logic [SizeBits-1:0]   rd_len;
  logic [IdxBits-1:0]    rd_addr;
  logic                  we;
  logic [IdxBits-1:0]    wr_addr;
  logic [OffsetBits-1:0] wr_start;
  logic [SizeBits-1:0]   wr_len;

  logic [SizeBits-1:0]   arena;
  logic [CntBits-1:0]    slot_count;
  logic [SizeBits-1:0]   free_total;

  bfa_req_t              r;
  logic [SizeBits-1:0]   align;
  logic [SizeBits:0]     need;
  logic [CntBits-1:0]    idx;        // entries issued
  logic [CntBits-1:0]    seen;       // entries compared
  logic                  found, has_prev, has_next, overlap;
  logic [IdxBits-1:0]    best, prev, nxt;
  logic [OffsetBits-1:0] best_s, prev_s, nxt_s;
  logic [SizeBits-1:0]   best_l, nxt_l;
  // pending second write (move last entry / add gap slot)
  logic [1:0]            phase;
  logic [IdxBits-1:0]    w2_addr;
  logic [OffsetBits-1:0] w2_start;
  logic [SizeBits-1:0]   w2_len;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_start[wr_addr] <= wr_start;
      mem_len[wr_addr]   <= wr_len;
    end
    rd_start <= mem_start[rd_addr];
    rd_len   <= mem_len[rd_addr];
  end

  logic [SizeBits:0] e_rd, end_f;
  logic [3:0] lg;
  always_comb begin
    e_rd  = {1'b0, rd_start} + (SizeBits+1)'(rd_len);
    end_f = (SizeBits+1)'(r.free_offset) + (SizeBits+1)'(r.request_size);
    lg    = (req.align_log2 > 4'(AlignMax)) ? 4'(AlignMax) : req.align_log2;
  end

  // decide values
  logic [SizeBits:0]   st, en, e0;
  logic [SizeBits-1:0] amask;
  always_comb begin
    amask = align - 1'b1;
    e0 = {1'b0, best_s} + (SizeBits+1)'(best_l);
    st = ({1'b0, best_s} + (SizeBits+1)'(amask)) & ~(SizeBits+1)'(amask);
    en = st + (SizeBits+1)'(r.request_size);
  end

  logic [SizeBits:0] cap_data;
  always_comb cap_data = (cfg_data > 21'(1 << OffsetBits)) ? 22'(1 << OffsetBits)
                                                           : {1'b0, cfg_data};

  always_comb begin
    rd_addr = idx[IdxBits-1:0];
    if (state == S_MOVE) rd_addr = IdxBits'(slot_count);
  end

  always_ff @(posedge clk) begin
    we   <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      state      <= S_IDLE;
      busy       <= 1'b0;
      arena      <= SizeBits'(1 << OffsetBits);
      slot_count <= CntBits'(1);
      free_total <= SizeBits'(1 << OffsetBits);
      we         <= 1'b1;
      wr_addr    <= '0;
      wr_start   <= '0;
      wr_len     <= SizeBits'(1 << OffsetBits);
    end else if (cfg_we) begin
      arena      <= cap_data[SizeBits-1:0];
      slot_count <= (cap_data != 0) ? CntBits'(1) : '0;
      free_total <= cap_data[SizeBits-1:0];
      we         <= 1'b1;
      wr_addr    <= '0;
      wr_start   <= '0;
      wr_len     <= cap_data[SizeBits-1:0];
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          r        <= req;
          align    <= SizeBits'(1) << lg;
          need     <= (SizeBits+1)'(req.request_size) + ((SizeBits+1)'(1) << lg) - 1'b1;
          idx      <= '0;
          seen     <= '0;
          found    <= 1'b0;
          has_prev <= 1'b0;
          has_next <= 1'b0;
          overlap  <= 1'b0;
          phase    <= '0;
          busy     <= 1'b1;
          state    <= S_SCAN;
        end
        S_SCAN, S_LAST: begin
          if (idx < slot_count) idx <= idx + 1'b1;
          if (state == S_LAST) begin
            // compare entry read last cycle
            if (seen < slot_count) begin
              if (r.command == CmdAlloc) begin
                if ({1'b0, rd_len} >= need && (!found || rd_len < best_l ||
                    (rd_len == best_l && rd_start < best_s))) begin
                  found <= 1'b1; best <= seen[IdxBits-1:0];
                  best_s <= rd_start; best_l <= rd_len;
                end
              end else begin
                if ({1'b0, rd_start} < end_f && e_rd > (SizeBits+1)'(r.free_offset))
                  overlap <= 1'b1;
                if ({1'b0, rd_start} == end_f) begin
                  has_next <= 1'b1; nxt <= seen[IdxBits-1:0];
                  nxt_s <= rd_start; nxt_l <= rd_len;
                end else if (e_rd == (SizeBits+1)'(r.free_offset)) begin
                  has_prev <= 1'b1; prev <= seen[IdxBits-1:0]; prev_s <= rd_start;
                end
              end
              seen <= seen + 1'b1;
            end else state <= S_DECIDE;
          end else state <= S_LAST;
        end
        S_DECIDE: begin
          res.alloc_offset <= '0;
          res.free_bytes <= free_total;
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b1;
          res.status <= StatusOk;
          if (r.command == CmdAlloc) begin
            if (!found) res.status <= StatusFit;
            else if (en == e0) begin
              res.alloc_offset <= st[OffsetBits-1:0];
              free_total <= free_total - r.request_size;
              res.free_bytes <= free_total - r.request_size;
              if (st > {1'b0, best_s}) begin
                we <= 1'b1; wr_addr <= best; wr_start <= best_s;
                wr_len <= SizeBits'(st - {1'b0, best_s});
              end else begin
                slot_count <= slot_count - 1'b1;
                if (CntBits'(best) != slot_count - 1'b1) begin
                  w2_addr <= best;
                  done <= 1'b0; busy <= 1'b1; state <= S_MOVE;
                end
              end
            end else if (st > {1'b0, best_s} && slot_count >= CntBits'(MaxSlots)) begin
              res.status <= StatusFull;
            end else begin
              res.alloc_offset <= st[OffsetBits-1:0];
              free_total <= free_total - r.request_size;
              res.free_bytes <= free_total - r.request_size;
              we <= 1'b1; wr_addr <= best; wr_start <= en[OffsetBits-1:0];
              wr_len <= SizeBits'(e0 - en);
              if (st > {1'b0, best_s}) begin
                w2_addr <= IdxBits'(slot_count);
                w2_start <= best_s; w2_len <= SizeBits'(st - {1'b0, best_s});
                slot_count <= slot_count + 1'b1;
                done <= 1'b0; busy <= 1'b1; state <= S_WRITE;
              end
            end
          end else if (r.request_size != 0) begin
            if (end_f > (SizeBits+1)'(arena) || overlap) res.status <= StatusFit;
            else if (has_prev && has_next) begin
              free_total <= free_total + r.request_size;
              res.free_bytes <= free_total + r.request_size;
              we <= 1'b1; wr_addr <= prev; wr_start <= prev_s;
              wr_len <= SizeBits'({1'b0, nxt_s} + (SizeBits+1)'(nxt_l)
                                  - {1'b0, prev_s});
              slot_count <= slot_count - 1'b1;
              if (CntBits'(nxt) != slot_count - 1'b1) begin
                w2_addr <= nxt;
                done <= 1'b0; busy <= 1'b1; state <= S_MOVE;
              end
            end else if (has_prev) begin
              free_total <= free_total + r.request_size;
              res.free_bytes <= free_total + r.request_size;
              we <= 1'b1; wr_addr <= prev; wr_start <= prev_s;
              wr_len <= SizeBits'(end_f - (SizeBits+1)'(prev_s));
            end else if (has_next) begin
              free_total <= free_total + r.request_size;
              res.free_bytes <= free_total + r.request_size;
              we <= 1'b1; wr_addr <= nxt; wr_start <= r.free_offset;
              wr_len <= SizeBits'((SizeBits+1)'(nxt_l) + (SizeBits+1)'(nxt_s)
                                  - (SizeBits+1)'(r.free_offset));
            end else if (slot_count >= CntBits'(MaxSlots)) res.status <= StatusFull;
            else begin
              free_total <= free_total + r.request_size;
              res.free_bytes <= free_total + r.request_size;
              we <= 1'b1; wr_addr <= IdxBits'(slot_count);
              wr_start <= r.free_offset; wr_len <= r.request_size;
              slot_count <= slot_count + 1'b1;
            end
          end
        end
        S_MOVE: begin
          // slot_count already reduced: read of the old last entry issued here;
          // the phase count lets a merge write to that entry land before it is read
          phase <= phase + 1'b1;
          if (phase == 2'd2) begin
            w2_start <= rd_start; w2_len <= rd_len; state <= S_WRITE;
          end
        end
        S_WRITE: begin
          we <= 1'b1; wr_addr <= w2_addr; wr_start <= w2_start; wr_len <= w2_len;
          done <= 1'b1; busy <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/bfa_checker.sv
// Checker: port-level assertions for the best-fit allocator, bound to the top level.
module bfa_checker import bfa_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input bfa_res_t res
);
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> res.status != 2'd3) else $error("bad status");
  a_offset: assert property (@(posedge clk) disable iff (rst)
    done && res.status != StatusOk |-> res.alloc_offset == '0) else $error("offset on fail");
endmodule

bind best_fit_allocator bfa_checker u_bfa_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .res(res));

>>> sim/testbench.sv
// Testbench for the best-fit allocator: directed table, then random requests checked by a predictor.
`timescale 1ns / 1ps
module testbench;
  import bfa_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     cfg_we = 1'b0;
  logic [20:0] cfg_data = '0;
  logic     start = 1'b0;
  bfa_req_t req = '0;
  logic     busy;
  logic     done;
  bfa_res_t res;

  best_fit_allocator i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .start(start), .req(req), .busy(busy), .done(done), .res(res)
  );

  always #2 clk = ~clk;

  // predictor state
  longint unsigned arena;
  longint unsigned slot_base[MaxSlots];
  longint unsigned slot_len[MaxSlots];
  int              slot_num;
  longint unsigned bytes_free;

  bfa_res_t pending_results[$];
  int       mismatches = 0;

  // live allocations, so that frees mostly return real ranges
  longint unsigned held_off[$];
  longint unsigned held_len[$];

  function automatic void arena_load(longint unsigned v);
    if (v > (64'd1 << OffsetBits)) v = 64'd1 << OffsetBits;
    arena = v;
    for (int i = 0; i < MaxSlots; i++) begin
      slot_base[i] = 0;
      slot_len[i] = 0;
    end
    slot_len[0] = v;
    slot_num = (v != 0) ? 1 : 0;
    bytes_free = v;
  endfunction

  function automatic void slot_remove(int i);
    int last;
    last = slot_num - 1;
    slot_base[i] = slot_base[last];
    slot_len[i] = slot_len[last];
    slot_num = last;
  endfunction

  function automatic logic [1:0] carve(longint unsigned size, longint unsigned lg,
                                       output longint unsigned off);
    longint unsigned align, need, s0, e0, st, en;
    int best;
    best = -1;
    off = 0;
    if (lg > AlignMax) lg = AlignMax;
    align = 64'd1 << lg;
    need = size + align - 1;
    for (int i = 0; i < slot_num; i++) begin
      if (slot_len[i] < need) continue;
      if (best < 0 || slot_len[i] < slot_len[best] ||
          (slot_len[i] == slot_len[best] && slot_base[i] < slot_base[best])) best = i;
    end
    if (best < 0) return StatusFit;
    s0 = slot_base[best];
    e0 = s0 + slot_len[best];
    st = (s0 + align - 1) & ~(align - 1);
    en = st + size;
    if (en == e0) begin
      if (st > s0) slot_len[best] = st - s0;
      else slot_remove(best);
    end else begin
      if (st > s0 && slot_num >= MaxSlots) return StatusFull;
      slot_base[best] = en;
      slot_len[best] = e0 - en;
      if (st > s0) begin
        slot_base[slot_num] = s0;
        slot_len[slot_num] = st - s0;
        slot_num++;
      end
    end
    bytes_free -= size;
    off = st;
    return StatusOk;
  endfunction

  function automatic logic [1:0] give_back(longint unsigned off, longint unsigned size);
    longint unsigned fin, s, e;
    int prv, nxt;
    prv = -1;
    nxt = -1;
    fin = off + size;
    if (size == 0) return StatusOk;
    if (fin > arena) return StatusFit;
    for (int i = 0; i < slot_num; i++) begin
      s = slot_base[i];
      e = s + slot_len[i];
      if (s < fin && e > off) return StatusFit;
      if (s == fin) nxt = i;
      else if (e == off) prv = i;
    end
    if (prv >= 0 && nxt >= 0) begin
      slot_len[prv] = slot_base[nxt] + slot_len[nxt] - slot_base[prv];
      slot_remove(nxt);
    end else if (prv >= 0) begin
      slot_len[prv] = fin - slot_base[prv];
    end else if (nxt >= 0) begin
      slot_len[nxt] += slot_base[nxt] - off;
      slot_base[nxt] = off;
    end else begin
      if (slot_num >= MaxSlots) return StatusFull;
      slot_base[slot_num] = off;
      slot_len[slot_num] = size;
      slot_num++;
    end
    bytes_free += size;
    return StatusOk;
  endfunction

  function automatic bfa_res_t predict_result(bfa_req_t r);
    bfa_res_t o;
    longint unsigned off;
    off = 0;
    if (r.command == CmdAlloc) begin
      o.status = carve(r.request_size, r.align_log2, off);
      if (o.status == StatusOk && r.request_size != 0) begin
        held_off.push_back(off);
        held_len.push_back(r.request_size);
      end
    end else begin
      o.status = give_back(r.free_offset, r.request_size);
    end
    o.alloc_offset = off[19:0];
    o.free_bytes = bytes_free[20:0];
    return o;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res);
      end else begin
        bfa_res_t want;
        want = pending_results.pop_front();
        if (res.status !== want.status || res.alloc_offset !== want.alloc_offset ||
            res.free_bytes !== want.free_bytes) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected st=%0d off=%0d free=%0d got st=%0d off=%0d free=%0d",
                     want.status, want.alloc_offset, want.free_bytes,
                     res.status, res.alloc_offset, res.free_bytes);
        end
      end
    end
  end

  task automatic issue(bfa_req_t r, bit has_fixed, bfa_res_t fixed);
    bfa_res_t p;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    repeat (gap) @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_result(r);
    if (has_fixed && p != fixed) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees with predictor %p %p", fixed, p);
    end
    pending_results.push_back(p);
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_arena(logic [20:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    arena_load(v);
    held_off.delete();
    held_len.delete();
  endtask

  function automatic bfa_req_t mk(logic c, logic [20:0] sz, logic [3:0] lg, logic [19:0] fo);
    bfa_req_t r;
    r.command = c;
    r.request_size = sz;
    r.align_log2 = lg;
    r.free_offset = fo;
    return r;
  endfunction

  function automatic bfa_res_t mkres(logic [1:0] s, logic [19:0] o, logic [20:0] f);
    bfa_res_t r;
    r.status = s;
    r.alloc_offset = o;
    r.free_bytes = f;
    return r;
  endfunction

  typedef struct {
    bfa_req_t r;
    bit       fixed;
    bfa_res_t want;
  } row_t;

  task automatic random_item();
    bfa_req_t r;
    int k, pick;
    r = '0;
    r.request_size = 21'($urandom);
    r.align_log2 = 4'($urandom);
    r.free_offset = 20'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      r.command = CmdAlloc;
      r.request_size = (pick < 40) ? 21'($urandom_range(0, 32'(arena / 16 + 1)))
                                   : r.request_size;
    end else if (pick < 85 && held_off.size() != 0) begin
      k = $urandom_range(0, held_off.size() - 1);
      r.command = CmdFree;
      r.free_offset = held_off[k][19:0];
      r.request_size = held_len[k][20:0];
      held_off.delete(k);
      held_len.delete(k);
    end else if (pick < 92 && held_off.size() != 0) begin
      // part of a live block, leaving the rest allocated
      k = $urandom_range(0, held_off.size() - 1);
      r.command = CmdFree;
      r.free_offset = held_off[k][19:0];
      r.request_size = 21'($urandom_range(1, 32'(held_len[k])));
      held_off[k] += r.request_size;
      held_len[k] -= r.request_size;
      if (held_len[k] == 0) begin
        held_off.delete(k);
        held_len.delete(k);
      end
    end else begin
      r.command = CmdFree;
      r.request_size = 21'($urandom_range(0, 4096));
    end
    issue(r, 1'b0, '0);
  endtask

  initial begin
    row_t rows[$];
    rows.push_back('{mk(CmdAlloc, 21'd100, 4'd0, 20'd0), 1'b1,
                     mkres(StatusOk, 20'd0, 21'd1048476)});
    rows.push_back('{mk(CmdAlloc, 21'd1, 4'd12, 20'd0), 1'b1,
                     mkres(StatusOk, 20'd4096, 21'd1048475)});
    rows.push_back('{mk(CmdAlloc, 21'd16, 4'd15, 20'd0), 1'b0, '0});
    rows.push_back('{mk(CmdAlloc, 21'h1FFFFF, 4'd0, 20'd0), 1'b1,
                     mkres(StatusFit, 20'd0, 21'd1048459)});
    rows.push_back('{mk(CmdAlloc, 21'd0, 4'd3, 20'd0), 1'b0, '0});
    rows.push_back('{mk(CmdFree, 21'd0, 4'd0, 20'd5), 1'b1,
                     mkres(StatusOk, 20'd0, 21'd1048459)});
    rows.push_back('{mk(CmdFree, 21'd8, 4'd0, 20'hFFFFC), 1'b1,
                     mkres(StatusFit, 20'd0, 21'd1048459)});
    rows.push_back('{mk(CmdFree, 21'd10, 4'd0, 20'd200), 1'b1,
                     mkres(StatusFit, 20'd0, 21'd1048459)});
    rows.push_back('{mk(CmdFree, 21'd100, 4'd0, 20'd0), 1'b0, '0});
    rows.push_back('{mk(CmdFree, 21'd100, 4'd0, 20'd0), 1'b1,
                     mkres(StatusFit, 20'd0, 21'd1048559)});
    rows.push_back('{mk(CmdFree, 21'd1, 4'd0, 20'd4096), 1'b0, '0});
    rows.push_back('{mk(CmdAlloc, 21'd50, 4'd4, 20'hFFFFF), 1'b0, '0});
    rows.push_back('{mk(CmdFree, 21'd10, 4'd0, 20'd20), 1'b0, '0});

    arena_load(64'd1048576);
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) issue(rows[i].r, rows[i].fixed, rows[i].want);

    // zero-size allocate against a fully allocated and then an emptied arena
    set_arena(21'd64);
    issue(mk(CmdAlloc, 21'd64, 4'd0, 20'd0), 1'b1, mkres(StatusOk, 20'd0, 21'd0));
    issue(mk(CmdAlloc, 21'd0, 4'd0, 20'd0), 1'b1, mkres(StatusFit, 20'd0, 21'd0));
    issue(mk(CmdFree, 21'd64, 4'd0, 20'd0), 1'b1, mkres(StatusOk, 20'd0, 21'd64));
    issue(mk(CmdAlloc, 21'd0, 4'd0, 20'd0), 1'b0, '0);
    // empty arena and saturating write
    set_arena(21'd0);
    issue(mk(CmdAlloc, 21'd0, 4'd0, 20'd0), 1'b1, mkres(StatusFit, 20'd0, 21'd0));
    set_arena(21'h1FFFFF);
    issue(mk(CmdAlloc, 21'd1048576, 4'd0, 20'd0), 1'b1, mkres(StatusOk, 20'd0, 21'd0));

    // fill the table with isolated holes, then push past it
    set_arena(21'd1);
    set_arena(21'd4096);
    for (int i = 0; i < 64; i++) issue(mk(CmdAlloc, 21'd64, 4'd0, 20'd0), 1'b0, '0);
    for (int i = 0; i < 66; i++)
      issue(mk(CmdFree, 21'd1, 4'd0, 20'(i * 62 + 1)), 1'b0, '0);
    issue(mk(CmdAlloc, 21'd1, 4'd1, 20'd0), 1'b0, '0);
    issue(mk(CmdAlloc, 21'd1, 4'd0, 20'd0), 1'b0, '0);
    for (int i = 0; i < 60; i++) random_item();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_arena(21'd1048576);
        1: set_arena(21'($urandom_range(1, 8192)));
        2: set_arena(21'd2048);
        default: set_arena(21'($urandom_range(1, 1048576)));
      endcase
      for (int i = 0; i < 90; i++) begin
        random_item();
        if (i == 60) drain();
      end
    end

    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("testbench: done, errors");
    $finish;
  end
endmodule

>>> filelist.f
rtl/bfa_pkg.sv
rtl/best_fit_allocator.sv
rtl/bfa_checker.sv
sim/testbench.sv
